/* rtl/hclp_pkg.sv */
// ============================================================================
// hclp_pkg
// Shared types, constants and per-byte parse functions of the
// Content-Length header parser.
// ============================================================================
`default_nettype none

package hclp_pkg;

  localparam int unsigned MaxHeaderBytes = 1024;
  localparam int unsigned CountW         = $clog2(MaxHeaderBytes + 1);
  localparam int unsigned LenW           = 32;
  localparam int unsigned HdrW           = 11;
  localparam int unsigned PosW           = 4;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxHeaderBytes);
  localparam logic [PosW-1:0]   NameLen  = PosW'(14);
  localparam logic [PosW-1:0]   PosSat   = PosW'(15);

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StHdrErr = 2'd1,
    StLenErr = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PhNone   = 2'd0,
    PhLead   = 2'd1,
    PhDigits = 2'd2,
    PhTrail  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MkNone   = 2'd0,
    MkCr     = 2'd1,
    MkCrLf   = 2'd2,
    MkCrLfCr = 2'd3
  } mark_e;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    mark_e             end_match;
    logic              pending_cr;
    logic              in_first_line;
    logic [PosW-1:0]   line_position;
    logic              name_matching;
    phase_e            value_phase;
    logic [LenW-1:0]   accumulator;
    logic              field_found;
    logic              length_error;
    logic              done;
  } parse_state_t;

  typedef struct packed {
    logic            valid;
    status_e         status;
    logic [LenW-1:0] body_len;
    logic [HdrW-1:0] header_bytes;
  } result_t;

  localparam parse_state_t ParseReset = '{
    byte_count:    '0,
    end_match:     MkNone,
    pending_cr:    1'b0,
    in_first_line: 1'b1,
    line_position: '0,
    name_matching: 1'b1,
    value_phase:   PhNone,
    accumulator:   '0,
    field_found:   1'b0,
    length_error:  1'b0,
    done:          1'b0
  };

  function automatic logic [7:0] label_char(input logic [PosW-1:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h6c; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab);
  endfunction

  function automatic parse_state_t take_value(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    logic         digit;
    logic         blank;
    logic [35:0]  next;
    r     = s;
    digit = (c >= 8'h30) && (c <= 8'h39);
    blank = is_blank(c);
    next  = {1'b0, s.accumulator, 3'b000} + {3'b000, s.accumulator, 1'b0} + {32'd0, c[3:0]};
    case (s.value_phase)
      PhLead: begin
        if (!blank) begin
          if (!digit) begin
            r.length_error = 1'b1;
            r.value_phase  = PhNone;
          end else begin
            r.accumulator = {28'd0, c[3:0]};
            r.value_phase = PhDigits;
          end
        end
      end
      PhDigits: begin
        if (blank) begin
          r.value_phase = PhTrail;
        end else if (!digit || next[35:32] != 4'd0) begin
          r.length_error = 1'b1;
          r.value_phase  = PhNone;
        end else begin
          r.accumulator = next[31:0];
        end
      end
      PhTrail: begin
        if (!blank) begin
          r.length_error = 1'b1;
          r.value_phase  = PhNone;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic parse_state_t take_line(input parse_state_t s, input logic [7:0] c);
    parse_state_t r;
    r = s;
    if (!s.in_first_line) begin
      if (s.line_position < NameLen) begin
        if (lower_ascii(c) != label_char(s.line_position)) begin
          r.name_matching = 1'b0;
        end
        r.line_position = s.line_position + PosW'(1);
      end else if (s.line_position == NameLen) begin
        if (s.name_matching && c == CharColon) begin
          if (s.field_found || s.length_error) begin
            r.length_error = 1'b1;
          end else begin
            r.accumulator = '0;
            r.value_phase = PhLead;
          end
        end
        r.line_position = PosSat;
      end else if (s.value_phase != PhNone) begin
        r = take_value(s, c);
      end
    end
    return r;
  endfunction

  function automatic parse_state_t end_line(input parse_state_t s);
    parse_state_t r;
    r = s;
    if (s.in_first_line) begin
      r.in_first_line = 1'b0;
    end else if (s.value_phase != PhNone) begin
      if (s.value_phase == PhLead || s.accumulator == '0) begin
        r.length_error = 1'b1;
      end else begin
        r.field_found = 1'b1;
      end
    end
    r.line_position = '0;
    r.name_matching = 1'b1;
    r.value_phase   = PhNone;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hclp_step.sv */
// ============================================================================
// hclp_step
// Per-byte update of the header parse state: end-marker tracking, line
// splitting, name match, value accumulation and result decision.
// ============================================================================
`default_nettype none

module hclp_step (
  input  hclp_pkg::parse_state_t state_i,
  input  logic [7:0]             data_i,
  input  logic                   first_i,
  output hclp_pkg::parse_state_t state_o,
  output hclp_pkg::result_t      result_o
);
  import hclp_pkg::*;

  always_comb begin
    parse_state_t s;
    result_t      res;
    logic         hit;
    logic         ok;
    s   = first_i ? ParseReset : state_i;
    res = '{valid: 1'b0, status: StOk, body_len: '0, header_bytes: '0};
    hit = 1'b0;
    ok  = 1'b0;
    if (!s.done) begin
      s.byte_count = s.byte_count + CountW'(1);

      case (data_i)
        CharCr:  s.end_match = (s.end_match == MkCrLf) ? MkCrLfCr : MkCr;
        CharLf: begin
          if (s.end_match == MkCrLfCr) begin
            s.end_match = MkNone;
            hit         = 1'b1;
          end else begin
            s.end_match = (s.end_match == MkCr) ? MkCrLf : MkNone;
          end
        end
        default: s.end_match = MkNone;
      endcase

      if (s.pending_cr && data_i == CharLf) begin
        s.pending_cr = 1'b0;
        s            = end_line(s);
      end else begin
        if (s.pending_cr) begin
          s.pending_cr = 1'b0;
          s            = take_line(s, CharCr);
        end
        if (data_i == CharCr) begin
          s.pending_cr = 1'b1;
        end else begin
          s = take_line(s, data_i);
        end
      end

      if (hit) begin
        ok                 = s.field_found && !s.length_error;
        res.valid          = 1'b1;
        res.status         = ok ? StOk : StLenErr;
        res.body_len       = ok ? s.accumulator : '0;
        res.header_bytes   = HdrW'(s.byte_count);
        s.done             = 1'b1;
      end else if (s.byte_count >= MaxCount) begin
        res.valid  = 1'b1;
        res.status = StHdrErr;
        s.done     = 1'b1;
      end
    end
    state_o  = s;
    result_o = res;
  end

endmodule

`default_nettype wire

/* rtl/http_content_length_parser.sv */
// Result path: the byte that completes a result word is accepted into the input
//   register, and the word is then registered in the result register.
// Throughput: one byte per cycle, multiply-by-ten included; a completing byte
//   waits only while the previous result word is still unread.
// Reset: rst_ni clears the parse state, so the first byte starts a request;
//   no clearing pass is needed.
// ============================================================================
// http_content_length_parser
// Streaming HTTP header scan that finds the blank-line end marker and
// extracts one Content-Length value per request.
// ============================================================================
`default_nettype none

module http_content_length_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tuser_i,  // [0] first_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [31:0] body_len, [42:32] header_bytes
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);
  import hclp_pkg::*;

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            in_data_q;
  logic                  in_first_q;
  parse_state_t          state_q;
  parse_state_t          state_d;
  result_t               res;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [LenW-1:0]       out_len_q;
  logic [HdrW-1:0]       out_hdr_q;
  logic                  advance;
  logic                  s_accept;

  hclp_step u_step (
    .state_i  (state_q),
    .data_i   (in_data_q),
    .first_i  (in_first_q),
    .state_o  (state_d),
    .result_o (res)
  );

  assign advance         = in_valid_q && (!res.valid || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ParseReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i;
    end
    if (advance && res.valid) begin
      out_status_q <= res.status;
      out_len_q    <= res.body_len;
      out_hdr_q    <= res.header_bytes;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_hdr_q, out_len_q};
  assign m_axis_tuser_o  = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_count <= MaxCount)
    else $error("byte count beyond header limit");

  a_rise_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && res.valid))
    else $error("result word without a completing byte");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.done && !in_first_q |-> !res.valid)
    else $error("result after request already finished");

  a_hdr_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == StHdrErr |-> out_len_q == '0 && out_hdr_q == '0)
    else $error("header error word carries data");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == StOk |-> out_len_q != '0)
    else $error("ok word with zero length");

endmodule

`default_nettype wire

/* tb/http_content_length_parser_tb.sv */
// ============================================================================
// http_content_length_parser_tb
// Streams HTTP request headers into the parser a byte per word and checks
// every result word against a byte-level scan model kept in the bench:
// directed header cases first, then mostly well-formed random requests mixed
// with truncated requests, trailing body bytes and raw noise, with random
// stalls on both sides, one long receiver hold-off and full drains.
// ============================================================================
`default_nettype none

module http_content_length_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hclp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       first;
    bit         drain;
    bit         hold_rx;
  } word_t;

  typedef struct {
    status_e     status;
    logic [31:0] length;
    logic [10:0] hdr_bytes;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_first = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [47:0] m_data;
  logic [1:0]  m_user;

  http_content_length_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_first),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  word_t       pending_words[$];
  verdict_t    verdicts_due[$];
  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned ok_seen = 0;
  int unsigned len_err_seen = 0;
  int unsigned hdr_err_seen = 0;
  string       nl = "\015\012";
  string       cr = "\015";
  string       label_text = "content-length";

  // header scan model
  int unsigned hb_count;
  mark_e       hb_mark;
  bit          hb_cr_wait;
  bit          hb_req_line;
  int unsigned hb_col;
  bit          hb_label_ok;
  phase_e      hb_phase;
  logic [31:0] hb_value;
  bit          hb_seen_len;
  bit          hb_len_bad;
  bit          hb_closed;

  task automatic clear_scan();
    hb_count    = 0;
    hb_mark     = MkNone;
    hb_cr_wait  = 1'b0;
    hb_req_line = 1'b1;
    hb_col      = 0;
    hb_label_ok = 1'b1;
    hb_phase    = PhNone;
    hb_value    = '0;
    hb_seen_len = 1'b0;
    hb_len_bad  = 1'b0;
    hb_closed   = 1'b0;
  endtask

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c ^ 8'h20 : c;
  endfunction

  task automatic reject_value();
    hb_len_bad = 1'b1;
    hb_phase   = PhNone;
  endtask

  task automatic value_char(input logic [7:0] c);
    bit                digit;
    bit                blank;
    logic [63:0]       wide;
    digit = (c >= "0") && (c <= "9");
    blank = (c == CharSpace) || (c == CharTab);
    case (hb_phase)
      PhLead: begin
        if (!blank) begin
          if (!digit) begin
            reject_value();
          end else begin
            hb_value = {24'd0, c - 8'h30};
            hb_phase = PhDigits;
          end
        end
      end
      PhDigits: begin
        if (blank) begin
          hb_phase = PhTrail;
        end else if (!digit) begin
          reject_value();
        end else begin
          wide = {32'd0, hb_value} * 64'd10 + {56'd0, c - 8'h30};
          if (wide > 64'hffff_ffff) reject_value();
          else hb_value = wide[31:0];
        end
      end
      PhTrail: begin
        if (!blank) reject_value();
      end
      default: ;
    endcase
  endtask

  task automatic line_char(input logic [7:0] c);
    if (hb_req_line) return;
    if (hb_col < 14) begin
      if (fold_case(c) != label_text[hb_col]) hb_label_ok = 1'b0;
      hb_col++;
    end else if (hb_col == 14) begin
      if (hb_label_ok && c == CharColon) begin
        if (hb_seen_len || hb_len_bad) begin
          hb_len_bad = 1'b1;
        end else begin
          hb_value = '0;
          hb_phase = PhLead;
        end
      end
      hb_col = 15;
    end else if (hb_phase != PhNone) begin
      value_char(c);
    end
  endtask

  task automatic close_line();
    if (hb_req_line) begin
      hb_req_line = 1'b0;
    end else if (hb_phase != PhNone) begin
      if (hb_phase == PhLead || hb_value == '0) hb_len_bad = 1'b1;
      else hb_seen_len = 1'b1;
    end
    hb_col      = 0;
    hb_label_ok = 1'b1;
    hb_phase    = PhNone;
  endtask

  task automatic scan_header_byte(input logic [7:0] b, input logic fresh);
    bit       hit;
    bit       ended;
    bit       ok;
    verdict_t v;
    if (fresh) clear_scan();
    if (hb_closed) return;
    hb_count++;
    hit   = 1'b0;
    ended = 1'b0;
    if (b == CharCr) begin
      hb_mark = (hb_mark == MkCrLf) ? MkCrLfCr : MkCr;
    end else if (b == CharLf) begin
      if (hb_mark == MkCrLfCr) begin
        hb_mark = MkNone;
        hit     = 1'b1;
      end else begin
        hb_mark = (hb_mark == MkCr) ? MkCrLf : MkNone;
      end
    end else begin
      hb_mark = MkNone;
    end
    if (hb_cr_wait) begin
      hb_cr_wait = 1'b0;
      if (b == CharLf) begin
        close_line();
        ended = 1'b1;
      end else begin
        line_char(CharCr);
      end
    end
    if (!ended) begin
      if (b == CharCr) hb_cr_wait = 1'b1;
      else line_char(b);
    end
    if (hit) begin
      ok          = hb_seen_len && !hb_len_bad;
      v.status    = ok ? StOk : StLenErr;
      v.length    = ok ? hb_value : 32'd0;
      v.hdr_bytes = 11'(hb_count);
      verdicts_due.push_back(v);
      hb_closed = 1'b1;
    end else if (hb_count >= MaxHeaderBytes) begin
      v.status    = StHdrErr;
      v.length    = '0;
      v.hdr_bytes = '0;
      verdicts_due.push_back(v);
      hb_closed = 1'b1;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sender
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  logic        rx_hold_go = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      clear_scan();
      s_valid    <= 1'b0;
      s_data     <= 8'h00;
      s_first    <= 1'b0;
      tx_gap     <= 0;
      tx_calm    <= 0;
      rx_hold_go <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        scan_header_byte(s_data, s_first);
        bytes_taken <= bytes_taken + 1;
      end
      if (!s_valid || s_ready) begin
        if (tx_gap != 0) begin
          tx_gap  <= tx_gap - 1;
          s_valid <= 1'b0;
        end else if (pending_words.size() != 0 && pending_words[0].drain) begin
          s_valid <= 1'b0;
          if (verdicts_due.size() == 0) void'(pending_words.pop_front());
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          s_valid <= 1'b1;
          s_data  <= w.data;
          s_first <= w.first;
          if (w.hold_rx) rx_hold_go <= 1'b1;
          if (tx_calm != 0) begin
            tx_calm <= tx_calm - 1;
            tx_gap  <= 0;
          end else begin
            tx_gap <= pick_gap();
            if ($urandom_range(0, 49) == 0) tx_calm <= $urandom_range(30, 150);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  int unsigned choke_cnt = 0;
  bit          choke_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choke_cnt  <= 0;
      choke_done <= 1'b0;
    end else if (choke_cnt != 0) begin
      choke_cnt <= choke_cnt - 1;
    end else if (rx_hold_go && !choke_done) begin
      choke_cnt  <= 1500;
      choke_done <= 1'b1;
    end
  end

  // receiver
  int unsigned rx_gap = 0;
  int unsigned rx_calm = 0;

  task automatic check_result();
    verdict_t v;
    if (verdicts_due.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result word at %0t: status %0d length %0d header_bytes %0d",
                 $time, m_user, m_data[31:0], m_data[42:32]);
      mismatches++;
      return;
    end
    v = verdicts_due.pop_front();
    case (v.status)
      StOk:     ok_seen++;
      StLenErr: len_err_seen++;
      default:  hdr_err_seen++;
    endcase
    if (m_user != v.status || m_data[31:0] != v.length || m_data[42:32] != v.hdr_bytes) begin
      if (mismatches < 10)
        $display("mismatch at %0t: status %0d/%0d length %0d/%0d header_bytes %0d/%0d %s",
                 $time, v.status, m_user, v.length, m_data[31:0], v.hdr_bytes,
                 m_data[42:32], "(expected/actual)");
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_gap  <= 0;
      rx_calm <= 0;
    end else begin
      if (m_valid && m_ready) check_result();
      if (rx_gap != 0) begin
        rx_gap  <= rx_gap - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= (choke_cnt == 0);
        if (rx_calm != 0) begin
          rx_calm <= rx_calm - 1;
        end else begin
          rx_gap <= pick_gap();
          if ($urandom_range(0, 49) == 0) rx_calm <= $urandom_range(30, 150);
        end
      end
    end
  end

  // stimulus
  int unsigned stim_bytes = 0;

  task automatic push_word(input logic [7:0] b, input logic first, input bit hold_rx = 1'b0);
    word_t w;
    w.data    = b;
    w.first   = first;
    w.drain   = 1'b0;
    w.hold_rx = hold_rx;
    pending_words.push_back(w);
  endtask

  task automatic push_request(input string s, input bit hold_rx = 1'b0);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == 0, hold_rx && i == 0);
    stim_bytes += s.len();
  endtask

  task automatic push_tail(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], 1'b0);
  endtask

  task automatic push_drain();
    word_t w;
    w.data    = 8'h00;
    w.first   = 1'b0;
    w.drain   = 1'b1;
    w.hold_rx = 1'b0;
    pending_words.push_back(w);
  endtask

  function automatic string fill(input string ch, input int unsigned n);
    string s;
    s = "";
    for (int unsigned i = 0; i < n; i++) s = {s, ch};
    return s;
  endfunction

  function automatic string garbage(input int unsigned n);
    string       s;
    logic [7:0]  b;
    s = "";
    for (int unsigned i = 0; i < n; i++) begin
      do b = 8'($urandom_range(1, 255)); while (b == CharCr || b == CharLf);
      s = $sformatf("%s%c", s, b);
    end
    return s;
  endfunction

  function automatic string mix_case(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
        s.putc(i, c ^ 8'h20);
    end
    return s;
  endfunction

  function automatic string blanks();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 1) != 0) s = {s, " "};
      else s = {s, "\t"};
    end
    return s;
  endfunction

  function automatic string random_value();
    case ($urandom_range(0, 11))
      0:       return "0";
      1:       return "4294967295";
      2:       return "4294967296";
      3:       return "99999999999";
      4:       return "";
      5:       return $sformatf("%0d", $urandom());
      6:       return $sformatf("000%0d", $urandom_range(0, 999));
      7:       return $sformatf("%0dx", $urandom_range(1, 99));
      8:       return $sformatf("%0d %0d", $urandom_range(1, 9), $urandom_range(0, 9));
      9:       return $sformatf("42949672%0d", $urandom_range(90, 99));
      default: return $sformatf("%0d", $urandom_range(1, 65535));
    endcase
  endfunction

  function automatic string length_line();
    return {mix_case("Content-Length"), ":", blanks(), random_value(), blanks()};
  endfunction

  function automatic string other_line();
    case ($urandom_range(0, 8))
      0:       return "Host: 192.168.1.10";
      1:       return "Accept: */*";
      2:       return "Content-Type: application/octet-stream";
      3:       return "Content-Lengt: 5";
      4:       return " Content-Length: 7";
      5:       return "Content-Length :7";
      6:       return "Content-Lengthy: 12";
      7:       return {"X-Tag: a", cr, "b"};
      default: return garbage($urandom_range(1, 30));
    endcase
  endfunction

  function automatic string random_request();
    string       s;
    int unsigned n;
    int unsigned at;
    bit          has_len;
    case ($urandom_range(0, 4))
      0:       s = "GET / HTTP/1.1";
      1:       s = "PUT /fw.bin HTTP/1.0";
      2:       s = garbage($urandom_range(1, 20));
      3:       s = "";
      default: s = "POST /upload HTTP/1.1";
    endcase
    s       = {s, nl};
    n       = $urandom_range(0, 4);
    at      = $urandom_range(0, n);
    has_len = $urandom_range(0, 99) < 85;
    for (int unsigned i = 0; i <= n; i++) begin
      if (i == at && has_len) s = {s, length_line(), nl};
      if (i < n) s = {s, other_line(), nl};
    end
    if ($urandom_range(0, 99) < 6) s = {s, length_line(), nl};
    return {s, nl};
  endfunction

  initial begin
    string       rl;
    string       pre;
    string       r;
    int unsigned kind;
    int unsigned whole;
    int unsigned unit;
    rl = {"GET /upload HTTP/1.1", nl};

    push_request({rl, "Content-Length: 42", nl, nl}, 1'b1);
    push_request({rl, "Host: a", nl, "cOnTeNt-LeNgTh:\t 4294967295 \t", nl, nl});
    push_request({rl, "content-length:4294967296", nl, nl});
    push_request({rl, "Content-Length: 99999999999", nl, nl});
    push_request({rl, "Content-Length: 0", nl, nl});
    push_request({rl, "CONTENT-LENGTH:000", nl, nl});
    push_request({rl, "Content-Length:", nl, nl});
    push_request({rl, "Content-Length: \t ", nl, nl});
    push_request({rl, "Content-Length: 12a", nl, nl});
    push_request({rl, "Content-Length: 1 2", nl, nl});
    push_request({rl, "Content-Length: 5", nl, "Content-Length: 5", nl, nl});
    push_request({rl, "Accept: */*", nl, nl});
    push_request({rl, "Content-Length :5", nl, " Content-Length: 5", nl,
                  "Content-Lengths: 5", nl, nl});
    push_request({rl, "X-Note: a", cr, "b", nl, "Content-Length: 00000000017", nl, nl});
    push_request({rl, "Content-Length: 9", cr, nl, nl});
    push_request({"Content-Length: 8", nl, nl});
    push_request({nl, nl});
    push_request({rl, "Content-Len"});
    push_request({rl, "Content-Length: 1", nl, nl});
    push_tail("hello");
    pre = {rl, "Content-Length: 3", nl, "X:"};
    push_request({pre, fill("a", 1025 - pre.len() - 4), nl, nl});
    push_drain();

    whole = 0;
    unit  = 0;
    stim_bytes = 0;
    while (stim_bytes < 400 || whole < 3) begin
      if (unit == 3) push_drain();
      kind = $urandom_range(0, 99);
      if (kind < 83) begin
        push_request(random_request(), unit == 12);
        if (kind >= 75) push_tail(garbage($urandom_range(1, 6)));
        whole++;
      end else if (kind < 91) begin
        r = random_request();
        push_request(r.substr(0, $urandom_range(0, r.len() - 2)), unit == 12);
      end else begin
        for (int unsigned k = 0; k < $urandom_range(1, 40); k++) begin
          push_word(8'($urandom_range(0, 255)), k == 0 || $urandom_range(0, 9) == 0,
                    unit == 12 && k == 0);
          stim_bytes++;
        end
      end
      unit++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || s_valid) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d header bytes taken, %0d results checked: %0d ok, %0d length errors, %0d %s",
             bytes_taken, ok_seen + len_err_seen + hdr_err_seen, ok_seen, len_err_seen,
             hdr_err_seen, "header overruns");
    if (mismatches == 0) begin
      $display("http_content_length_parser verification clean");
    end else begin
      $display("http_content_length_parser verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", verdicts_due.size());
    $display("http_content_length_parser verification failed");
    $finish;
  end

endmodule

`default_nettype wire
